FILE: src/vfdgsf_pkg.sv
// Shared types, constants and pixel packing for the grid scan formatter.
`timescale 1ns / 1ps
package vfdgsf_pkg;

  localparam int BytesPerPage = 6;
  localparam int PageW        = 3;   // page field width
  localparam int ColW         = 8;   // scan column width, 3*62+2 fits
  localparam int GridW        = 6;
  localparam logic [7:0] BrightnessReset = 8'd128;
  localparam logic       RegBrightness   = 1'b0;   // word index of brightness
  localparam logic       ActWrite        = 1'b0;
  localparam logic       ActTick         = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN
  } state_t;

  // one formatted page handed from the reader to the output stage
  typedef struct packed {
    logic                    load;
    logic                    start;
    logic                    last_page;
    logic [GridW-1:0]        grid;
    logic [8*BytesPerPage-1:0] bytes;
  } emit_load_t;

  // Pack the three columns of one grid and page into six serial bytes.
  function automatic logic [8*BytesPerPage-1:0] pack_page(input logic [7:0] c0,
                                                          input logic [7:0] c1,
                                                          input logic [7:0] c2,
                                                          input logic odd);
    logic [7:0]                cols [3];
    logic [8*BytesPerPage-1:0] r;
    cols[0] = c0;
    cols[1] = c1;
    cols[2] = c2;
    r = '0;
    for (int k = 0; k < 24; k++) begin
      if (odd) begin
        r[(k / 4) * 8 + 2 * (k % 4) + 1] = cols[2 - (k % 3)][k / 3];
      end else begin
        r[(k / 4) * 8 + 2 * (k % 4)] = cols[k % 3][k / 3];
      end
    end
    return r;
  endfunction

endpackage

FILE: src/vfdgsf_ram.sv
// Frame store: one write port, one registered read port.
`timescale 1ns / 1ps
module vfdgsf_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/vfdgsf_emit.sv
// Output stage: holds one formatted page and sends its six bytes as beats.
`timescale 1ns / 1ps
module vfdgsf_emit (
  input  logic                    clk,
  input  logic                    rst,
  input  vfdgsf_pkg::emit_load_t  ld,
  input  logic [7:0]              dim_level,
  output logic                    can_load,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [23:0]             m_axis_tdata,  // serial_byte, grid_number, dim_level, pad
  output logic                    m_axis_tuser,  // frame_start
  output logic                    m_axis_tlast
);
  import vfdgsf_pkg::*;

  logic [8*BytesPerPage-1:0] pbuf;
  logic [2:0]                idx;
  logic                      full;
  logic                      start;
  logic                      last_page;
  logic [GridW-1:0]          grid;
  logic                      fire;
  logic                      at_end;

  assign fire     = full && m_axis_tready;
  assign at_end   = (idx == 3'(BytesPerPage - 1));
  assign can_load = !full || (fire && at_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (ld.load) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (fire) begin
      if (at_end) begin
        full <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      pbuf      <= ld.bytes;
      start     <= ld.start;
      last_page <= ld.last_page;
      grid      <= ld.grid;
    end
  end

  assign m_axis_tvalid = full;
  assign m_axis_tdata  = {2'b00, dim_level, grid, pbuf[8*idx +: 8]};
  assign m_axis_tuser  = start;
  assign m_axis_tlast  = last_page && at_end;

endmodule

FILE: src/vfdgsf_grid_scan_top_placeholder.sv
// Read sequencer: fetches the three columns of each page and gathers them.
`timescale 1ns / 1ps
module vfdgsf_reader #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8,
  parameter int AW      = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start_scan,
  input  logic [vfdgsf_pkg::ColW-1:0]  base_col,
  input  logic                         active,
  input  logic                         can_load,
  input  logic [7:0]                   mem_q,
  output logic                         re,
  output logic [AW-1:0]                raddr,
  output logic                         gather_full,
  output logic                         rd_wait,
  output logic                         xfer,
  output logic                         last_page,
  output logic [8*vfdgsf_pkg::BytesPerPage-1:0] bytes,
  input  logic                         odd
);
  import vfdgsf_pkg::*;

  logic [PageW-1:0] rd_page;
  logic [1:0]       rd_sub;
  logic [PageW-1:0] xfer_page;
  logic             rvld_q;
  logic [1:0]       sub_q;
  logic             zero_q;
  logic [7:0]       gather [3];
  logic [ColW-1:0]  col_rd;
  logic             col_ok;

  assign col_rd    = base_col + ColW'(rd_sub);
  assign col_ok    = (32'(col_rd) < COLUMNS);
  assign re        = active && !rd_wait;
  assign raddr     = col_ok ? AW'(32'(rd_page) * COLUMNS + 32'(col_rd)) : '0;
  assign xfer      = gather_full && can_load;
  assign last_page = (xfer_page == PageW'(PAGES - 1));
  assign bytes     = pack_page(gather[0], gather[1], gather[2], odd);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_wait     <= 1'b1;
      gather_full <= 1'b0;
      rvld_q      <= 1'b0;
      rd_page     <= '0;
      rd_sub      <= '0;
      xfer_page   <= '0;
    end else if (start_scan) begin
      rd_wait     <= 1'b0;
      gather_full <= 1'b0;
      rvld_q      <= 1'b0;
      rd_page     <= '0;
      rd_sub      <= '0;
      xfer_page   <= '0;
    end else begin
      rvld_q <= re;
      if (re) begin
        if (rd_sub == 2'd2) begin
          rd_sub  <= '0;
          rd_wait <= 1'b1;
          rd_page <= rd_page + PageW'(1);
        end else begin
          rd_sub <= rd_sub + 2'd1;
        end
      end
      if (rvld_q && sub_q == 2'd2) begin
        gather_full <= 1'b1;
      end
      // hand the page over; resume fetching unless this was the final page
      if (xfer) begin
        gather_full <= 1'b0;
        xfer_page   <= xfer_page + PageW'(1);
        if (!last_page) begin
          rd_wait <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sub_q  <= rd_sub;
    zero_q <= !col_ok;
    if (rvld_q) begin
      gather[sub_q] <= zero_q ? 8'h00 : mem_q;
    end
  end

endmodule

FILE: src/vfd_grid_scan_formatter_unit.sv
// Top level of the grid scan formatter: framebuffer, scan control and config.
`timescale 1ns / 1ps
// Usage:
//   Input stream s_axis: tuser is the action. Action write stores pixel_byte at
//   (column, page) in the frame store; out-of-range positions are dropped. Action
//   tick formats one display grid and sends 6*PAGES beats (48 by default) on
//   m_axis, page by page, six bytes per page. tlast marks the final beat of the
//   grid (latch point), tuser marks every beat of the first grid of a frame.
//   Grids count down from GRID_COUNT-1 to 0, then the frame restarts.
// Timing:
//   A tick is accepted only when the previous grid is fully sent; its first beat
//   appears once the first page has been fetched, gathered and loaded into the
//   output stage. The single read port of the frame store fetches three columns
//   per page, overlapped with the six output beats of the page before, so the
//   output stage sets the rate.
// Reset:
//   rst is synchronous. After it the block sweeps the frame store to zero, one
//   entry per cycle, all COLUMNS*PAGES entries (1024 by default); s_axis_tready
//   stays low meanwhile. APB writes are taken at any time.
// Stall:
//   A low m_axis_tready holds the current beat; fetching pauses once the next
//   page is gathered, and no data is lost.
// Config: APB register 0 is brightness (reset 128); dim_level = 255 - brightness.
module vfd_grid_scan_formatter_unit #(
  parameter int GRID_COUNT = 43,
  parameter int COLUMNS    = 128,
  parameter int PAGES      = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // column[6:0], page[9:7], pixel_byte[17:10], pad
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // serial_byte, grid_number, dim_level, pad
  output logic        m_axis_tuser,   // frame_start
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vfdgsf_pkg::*;

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state;
  state_t state_next;

  logic [AW-1:0]    clr_addr;
  logic [GridW-1:0] grids_left;
  logic [GridW-1:0] grid_load;
  logic [GridW-1:0] grid;
  logic             start;
  logic [ColW-1:0]  base_col;
  logic [7:0]       brightness;
  logic [7:0]       dim_level;

  logic             s_fire;
  logic             m_fire;
  logic             tick;
  logic             clearing;
  logic             active;

  logic [6:0]       wr_col;
  logic [PageW-1:0] wr_page;
  logic [7:0]       wr_byte;
  logic             wr_ok;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_q;

  logic             can_load;
  logic             gather_full;
  logic             rd_wait;
  logic             xfer;
  logic             last_page;
  logic [8*BytesPerPage-1:0] page_bytes;
  emit_load_t       ld;

  assign wr_col  = s_axis_tdata[6:0];
  assign wr_page = s_axis_tdata[9:7];
  assign wr_byte = s_axis_tdata[17:10];

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign tick   = s_fire && (s_axis_tuser == ActTick);
  assign wr_ok  = s_fire && (s_axis_tuser == ActWrite) &&
                  (32'(wr_col) < COLUMNS) && (32'(wr_page) < PAGES);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (tick) state_next = ST_SCAN;
      ST_SCAN:  if (m_fire && m_axis_tlast) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    clearing      = 1'b0;
    active        = 1'b0;
    case (state)
      ST_CLEAR: clearing      = 1'b1;
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_SCAN:  active        = 1'b1;
      default:  clearing      = 1'b0;
    endcase
  end

  // restart the frame when no grids are left
  assign grid_load = (grids_left == '0) ? GridW'(GRID_COUNT) : grids_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      grids_left <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (tick) begin
        grids_left <= grid_load - GridW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      grid     <= grid_load - GridW'(1);
      start    <= (grids_left == '0);
      base_col <= ColW'(3) * ColW'(grid_load - GridW'(1));
    end
  end

  // frame store write port: clearing sweep or pixel write
  assign mem_we    = clearing || wr_ok;
  assign mem_waddr = clearing ? clr_addr : AW'(32'(wr_page) * COLUMNS + 32'(wr_col));
  assign mem_wdata = clearing ? 8'h00 : wr_byte;

  vfdgsf_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  vfdgsf_reader #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .AW      (AW)
  ) u_reader (
    .clk         (clk),
    .rst         (rst),
    .start_scan  (tick),
    .base_col    (base_col),
    .active      (active),
    .can_load    (can_load),
    .mem_q       (mem_q),
    .re          (mem_re),
    .raddr       (mem_raddr),
    .gather_full (gather_full),
    .rd_wait     (rd_wait),
    .xfer        (xfer),
    .last_page   (last_page),
    .bytes       (page_bytes),
    .odd         (grid[0])
  );

  assign ld.load      = xfer;
  assign ld.start     = start;
  assign ld.last_page = last_page;
  assign ld.grid      = grid;
  assign ld.bytes     = page_bytes;

  assign dim_level = ~brightness;

  vfdgsf_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .ld            (ld),
    .dim_level     (dim_level),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BrightnessReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegBrightness) begin
      brightness <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == RegBrightness) ? {24'h0, brightness} : 32'h0;

  // no beats while the frame store is still being cleared
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !m_axis_tvalid)
    else $error("output beat during clearing sweep");

  // a gathered page must have stopped the fetch sequencer
  a_gather_pauses_fetch: assert property (@(posedge clk) disable iff (rst)
    gather_full |-> rd_wait)
    else $error("fetch running while gathered page is pending");

  // the final beat of a grid returns the block to accepting input
  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (m_fire && m_axis_tlast) |=> s_axis_tready)
    else $error("input not ready after final beat");

  // no pixel write can overlap a scan
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    active |-> !mem_we)
    else $error("frame store written during scan");

endmodule
